// ----- hdl/mrss_pkg.sv -----
// Shared widths and types for the Morton range split search block.
`timescale 1ns / 1ps

package mrss_pkg;

    // Index fields are fixed at ten bits on the stream.
    localparam int IDX_W = 10;
    // Code field width on the stream.
    localparam int CODE_IN_W = 32;

    // Slave tdata: entry_index, entry_code, range_first, range_last, padded to bytes.
    localparam int S_FIELDS_W = IDX_W + CODE_IN_W + IDX_W + IDX_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    // Master tdata: split_index padded to bytes.
    localparam int M_TDATA_W  = ((IDX_W + 7) / 8) * 8;

    // Bit offsets inside s_tdata.
    localparam int ENTRY_INDEX_LSB = 0;
    localparam int ENTRY_CODE_LSB  = ENTRY_INDEX_LSB + IDX_W;
    localparam int RANGE_FIRST_LSB = ENTRY_CODE_LSB + CODE_IN_W;
    localparam int RANGE_LAST_LSB  = RANGE_FIRST_LSB + IDX_W;

    typedef logic [IDX_W-1:0] idx_t;

    // Item kind carried on s_tuser.
    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_QUERY = 1'b1
    } kind_t;

endpackage

// ----- hdl/mrss_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module mrss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/mrss_cmp.sv -----
// Prefix compare unit: common-prefix mask of the end codes and probe match test.
`timescale 1ns / 1ps

module mrss_cmp #(
    parameter int CODE_BITS = 32
) (
    input  logic [CODE_BITS-1:0] start_code,
    input  logic [CODE_BITS-1:0] stop_code,
    input  logic [CODE_BITS-1:0] probe_code,
    input  logic [CODE_BITS-1:0] prefix_mask,
    output logic [CODE_BITS-1:0] end_mask,
    output logic                 probe_match
);

    logic [CODE_BITS-1:0] smear;

    // Smear the highest differing bit of the end codes down to bit zero.
    always_comb begin
        smear = start_code ^ stop_code;
        for (int k = 1; k < CODE_BITS; k = k * 2) begin
            smear = smear | (smear >> k);
        end
    end

    // Mask covers the common prefix plus the first differing bit.
    assign end_mask = ~(smear >> 1);

    // Probe shares more leading bits than the end codes when no masked bit differs.
    assign probe_match = ((start_code ^ probe_code) & prefix_mask) == '0;

endmodule

// ----- hdl/morton_range_split_search.sv -----
// Top level of the Morton range split search: code table, search sequencer, result register.
//
//  channel | ports                          | content
//  --------+--------------------------------+------------------------------------------------
//  input   | s_tvalid s_tready s_tdata      | tdata: entry_index, entry_code, range_first,
//          | s_tuser                        |        range_last; tuser: kind
//  result  | m_tvalid m_tready m_tdata      | tdata: split_index; tuser: range_error
//          | m_tuser                        |
//
// Sequence: a write item is taken in S_IDLE. A query reads the two end codes one after the other,
// then, unless they are equal, runs ceil(log2(last - first)) halving steps, at least one, each a
// probe state plus a test state when the probe lies below last, the probe state alone otherwise,
// and then hands the result over from S_DONE. The code table has a single read port.
// A reversed range goes straight to S_DONE without reads.
// Reset: aresetn is synchronous, active low; it clears the sequencer and the result valid.
// The table holds no reset value. Stalls: a finished result waits in the output register
// while the next item is taken; the sequencer holds only if a second result is ready first.
`timescale 1ns / 1ps

module morton_range_split_search #(
    parameter int TABLE_DEPTH = 1024,
    parameter int CODE_BITS   = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [9:0] entry_index, [41:10] entry_code, [51:42] range_first, [61:52] range_last
    input  logic [mrss_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] kind
    input  logic [0:0]                     s_tuser,

    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [9:0] split_index
    output logic [mrss_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] range_error
    output logic [0:0]                     m_tuser
);

    localparam int IDX_W  = mrss_pkg::IDX_W;
    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    // Wide enough for both the stream index and the table address.
    localparam int EXT_W  = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;
    localparam logic [EXT_W:0] DEPTH_C = (EXT_W + 1)'(TABLE_DEPTH);
    localparam int CW_EXT = (CODE_BITS > mrss_pkg::CODE_IN_W) ? CODE_BITS : mrss_pkg::CODE_IN_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LAST  = 6'b000010,
        S_ENDS  = 6'b000100,
        S_PROBE = 6'b001000,
        S_TEST  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    // Input field unpacking.
    mrss_pkg::idx_t                 in_entry_index;
    logic [mrss_pkg::CODE_IN_W-1:0] in_entry_code;
    mrss_pkg::idx_t                 in_first;
    mrss_pkg::idx_t                 in_last;
    mrss_pkg::kind_t                in_kind;

    assign in_entry_index = s_tdata[mrss_pkg::ENTRY_INDEX_LSB +: IDX_W];
    assign in_entry_code  = s_tdata[mrss_pkg::ENTRY_CODE_LSB +: mrss_pkg::CODE_IN_W];
    assign in_first       = s_tdata[mrss_pkg::RANGE_FIRST_LSB +: IDX_W];
    assign in_last        = s_tdata[mrss_pkg::RANGE_LAST_LSB +: IDX_W];
    assign in_kind        = mrss_pkg::kind_t'(s_tuser[0]);

    // Control registers.
    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   rd_oob_reg, rd_oob_next;

    // Working registers.
    mrss_pkg::idx_t       first_reg, first_next;
    mrss_pkg::idx_t       last_reg, last_next;
    mrss_pkg::idx_t       pos_reg, pos_next;
    mrss_pkg::idx_t       step_reg, step_next;
    mrss_pkg::idx_t       probe_reg, probe_next;
    logic [CODE_BITS-1:0] fc_reg, fc_next;
    logic [CODE_BITS-1:0] mask_reg, mask_next;
    mrss_pkg::idx_t       res_idx_reg, res_idx_next;
    logic                 res_err_reg, res_err_next;
    mrss_pkg::idx_t       m_idx_reg, m_idx_next;
    logic                 m_err_reg, m_err_next;

    logic s_accept;
    logic out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // Write side of the code table: drop writes beyond the table depth.
    logic [EXT_W-1:0]     wr_ext;
    logic                 wr_in_range;
    logic [CW_EXT-1:0]    wr_code_ext;
    logic                 ram_we;
    logic [CODE_BITS-1:0] ram_wdata;

    assign wr_ext      = EXT_W'(in_entry_index);
    assign wr_in_range = {1'b0, wr_ext} < DEPTH_C;
    assign wr_code_ext = CW_EXT'(in_entry_code);
    assign ram_wdata   = wr_code_ext[CODE_BITS-1:0];
    assign ram_we      = s_accept && (in_kind == mrss_pkg::KIND_WRITE) && wr_in_range;

    // Read side: an address beyond the depth reads as zero.
    logic                 rd_en;
    mrss_pkg::idx_t       rd_idx;
    logic [EXT_W-1:0]     rd_ext;
    logic                 rd_in_range;
    logic [CODE_BITS-1:0] ram_rdata;
    logic [CODE_BITS-1:0] rd_code;

    assign rd_ext      = EXT_W'(rd_idx);
    assign rd_in_range = {1'b0, rd_ext} < DEPTH_C;
    assign rd_code     = rd_oob_reg ? '0 : ram_rdata;

    mrss_ram #(
        .WIDTH (CODE_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wr_ext[ADDR_W-1:0]),
        .wdata (ram_wdata),
        .re    (rd_en),
        .raddr (rd_ext[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // Prefix compare: end mask against the last code, probe match against the held mask.
    logic [CODE_BITS-1:0] end_mask;
    logic                 probe_match;

    mrss_cmp #(
        .CODE_BITS (CODE_BITS)
    ) u_cmp (
        .start_code  (fc_reg),
        .stop_code   (rd_code),
        .probe_code  (rd_code),
        .prefix_mask (mask_reg),
        .end_mask    (end_mask),
        .probe_match (probe_match)
    );

    // Halving step and probe position.
    logic [IDX_W:0] step_inc;
    mrss_pkg::idx_t step_half;
    logic [IDX_W:0] probe_sum;
    logic [IDX_W:0] mid_sum;

    assign step_inc  = (IDX_W + 1)'(step_reg) + (IDX_W + 1)'(1);
    assign step_half = step_inc[IDX_W:1];
    assign probe_sum = (IDX_W + 1)'(pos_reg) + (IDX_W + 1)'(step_half);
    assign mid_sum   = (IDX_W + 1)'(first_reg) + (IDX_W + 1)'(last_reg);

    // Search sequencer.
    always_comb begin
        state_next   = state_reg;
        first_next   = first_reg;
        last_next    = last_reg;
        pos_next     = pos_reg;
        step_next    = step_reg;
        probe_next   = probe_reg;
        fc_next      = fc_reg;
        mask_next    = mask_reg;
        res_idx_next = res_idx_reg;
        res_err_next = res_err_reg;
        rd_en        = 1'b0;
        rd_idx       = first_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_accept && (in_kind == mrss_pkg::KIND_QUERY)) begin
                    first_next = in_first;
                    last_next  = in_last;
                    if (in_first > in_last) begin
                        // Reversed range: flag it and hand back first.
                        res_idx_next = in_first;
                        res_err_next = 1'b1;
                        state_next   = S_DONE;
                    end else begin
                        rd_en      = 1'b1;
                        rd_idx     = in_first;
                        state_next = S_LAST;
                    end
                end
            end
            S_LAST: begin
                // First code arrives; issue the read of the last code.
                fc_next    = rd_code;
                rd_en      = 1'b1;
                rd_idx     = last_reg;
                state_next = S_ENDS;
            end
            S_ENDS: begin
                if (rd_code == fc_reg) begin
                    res_idx_next = mid_sum[IDX_W:1];
                    res_err_next = 1'b0;
                    state_next   = S_DONE;
                end else begin
                    mask_next  = end_mask;
                    pos_next   = first_reg;
                    step_next  = last_reg - first_reg;
                    state_next = S_PROBE;
                end
            end
            S_PROBE: begin
                step_next = step_half;
                if (probe_sum < (IDX_W + 1)'(last_reg)) begin
                    rd_en      = 1'b1;
                    rd_idx     = probe_sum[IDX_W-1:0];
                    probe_next = probe_sum[IDX_W-1:0];
                    state_next = S_TEST;
                end else if (step_half <= IDX_W'(1)) begin
                    res_idx_next = pos_reg;
                    res_err_next = 1'b0;
                    state_next   = S_DONE;
                end
            end
            S_TEST: begin
                // Advance pos when the probe shares a longer prefix with the first code.
                if (probe_match) begin
                    pos_next = probe_reg;
                end
                if (step_reg > IDX_W'(1)) begin
                    state_next = S_PROBE;
                end else begin
                    res_idx_next = probe_match ? probe_reg : pos_reg;
                    res_err_next = 1'b0;
                    state_next   = S_DONE;
                end
            end
            S_DONE: begin
                // Hold the result until the output register frees up.
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rd_oob_next = rd_en ? !rd_in_range : rd_oob_reg;

    // Output register: load from the sequencer, drop once taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_idx_next   = m_idx_reg;
        m_err_next   = m_err_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if ((state_reg == S_DONE) && out_free) begin
            m_valid_next = 1'b1;
            m_idx_next   = res_idx_reg;
            m_err_next   = res_err_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            rd_oob_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            rd_oob_reg  <= rd_oob_next;
        end
    end

    always_ff @(posedge aclk) begin
        first_reg   <= first_next;
        last_reg    <= last_next;
        pos_reg     <= pos_next;
        step_reg    <= step_next;
        probe_reg   <= probe_next;
        fc_reg      <= fc_next;
        mask_reg    <= mask_next;
        res_idx_reg <= res_idx_next;
        res_err_reg <= res_err_next;
        m_idx_reg   <= m_idx_next;
        m_err_reg   <= m_err_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = mrss_pkg::M_TDATA_W'(m_idx_reg);
    assign m_tuser  = m_err_reg;

`ifndef SYNTHESIS
    // A probe is only read when it lies strictly inside the range.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TEST) |-> (probe_reg > pos_reg) && (probe_reg < last_reg))
        else $error("probe outside the search range");

    // The running split stays in [first, last) during the search.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PROBE || state_reg == S_TEST)
        |-> (pos_reg >= first_reg) && (pos_reg < last_reg))
        else $error("split position left the range");

    // The halving step never reaches zero while searching.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PROBE || state_reg == S_TEST) |-> (step_reg != '0))
        else $error("search step collapsed to zero");

    // A flagged result carries the first index of a reversed range.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && res_err_reg) |-> (res_idx_reg == first_reg)
        && (first_reg > last_reg))
        else $error("range error without a reversed range");

    // No table write while a query is in flight.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_IDLE))
        else $error("table write during a search");
`endif

endmodule
